// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. Each form samples on clk and is
// disabled while rst_n is low. Defining SYNTH turns every use into nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// The expression holds at every clock edge.
`define ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// When ante holds, cons holds at the same edge.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// When ante holds, cons holds at the next edge.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, expr, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/tbw_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_pkg
// Types, codes and constant tables of the tile background and window
// pixel generator.
// ----------------------------------------------------------------------------
package tbw_pkg;

  // Function codes of an input beat.
  localparam logic [1:0] FUNC_VRAM_WR = 2'd0;
  localparam logic [1:0] FUNC_PAL_WR  = 2'd1;
  localparam logic [1:0] FUNC_PIXEL   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] CFG_LCDC       = 3'd0;
  localparam logic [2:0] CFG_SCROLL_X   = 3'd1;
  localparam logic [2:0] CFG_SCROLL_Y   = 3'd2;
  localparam logic [2:0] CFG_WINDOW_X   = 3'd3;
  localparam logic [2:0] CFG_WINDOW_Y   = 3'd4;
  localparam logic [2:0] CFG_BG_PALETTE = 3'd5;
  localparam logic [2:0] CFG_COLOR_MODE = 3'd6;

  // Reset values of the registers.
  localparam logic [7:0] LCDC_RESET       = 8'd145;
  localparam logic [7:0] BG_PALETTE_RESET = 8'd252;

  // LCD control bit positions.
  localparam int LCDC_ENABLE   = 0;
  localparam int LCDC_BG_MAP   = 3;
  localparam int LCDC_UNSIGNED = 4;
  localparam int LCDC_WIN_EN   = 5;
  localparam int LCDC_WIN_MAP  = 6;

  // Tile map bases.
  localparam logic [12:0] MAP_BASE_LO = 13'h1800;
  localparam logic [12:0] MAP_BASE_HI = 13'h1C00;

  // Each video bank and the palette memory are split into an even and an
  // odd half, so that both bytes of a pair at an even address read in the same cycle.
  localparam int VRAM_HALF_DEPTH = 4096;
  localparam int PAL_HALF_DEPTH  = 32;
  localparam int VRAM_AW         = $clog2(VRAM_HALF_DEPTH);
  localparam int PAL_AW          = $clog2(PAL_HALF_DEPTH);
  localparam int QUEUE_DEPTH     = 2;

  typedef struct packed {
    logic [7:0] lcd_control;
    logic [7:0] scroll_x;
    logic [7:0] scroll_y;
    logic [7:0] window_x;
    logic [7:0] window_y;
    logic [7:0] bg_palette_map;
    logic       color_mode;
  } cfg_t;

  typedef enum logic [1:0] {
    OP_VRAM_WR,
    OP_PAL_WR,
    OP_PIXEL,
    OP_BLANK
  } op_t;

  // One queued job. For a pixel, addr holds the tile map address.
  typedef struct packed {
    op_t        op;
    logic       bank;
    logic [12:0] addr;
    logic [7:0] data;
    logic [2:0] fine_x;
    logic [2:0] fine_y;
  } entry_t;

  // floor(c * 255 / 31) for a 5-bit channel.
  localparam logic [7:0] SCALE5 [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // The four fixed mono shades.
  localparam logic [7:0] SHADE_R [4] = '{8'd224, 8'd140, 8'd72, 8'd24};
  localparam logic [7:0] SHADE_G [4] = '{8'd232, 8'd160, 8'd88, 8'd32};
  localparam logic [7:0] SHADE_B [4] = '{8'd184, 8'd112, 8'd72, 8'd28};

  function automatic logic [15:0] pack565(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] shade565(logic [1:0] s);
    return pack565(SHADE_R[s], SHADE_G[s], SHADE_B[s]);
  endfunction

  // v is a 15-bit BGR palette entry.
  function automatic logic [15:0] palette565(logic [14:0] v);
    return pack565(SCALE5[v[4:0]], SCALE5[v[9:5]], SCALE5[v[14:10]]);
  endfunction

endpackage

// ===== rtl/tbw_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tbw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/tbw_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_front
// Input side: classifies each beat and, for a pixel request, picks window
// or scrolled background and forms the tile map address.
// ----------------------------------------------------------------------------
module tbw_front import tbw_pkg::*; #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 144
) (
  input  logic        in_valid,
  input  logic [1:0]  in_func,
  input  logic        in_bank,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,
  input  cfg_t        cfg,
  input  logic        q_full,
  output logic        push,
  output entry_t      push_entry
);

  // The window left edge is window_x - 7; compares are shifted by 7 so that
  // everything stays unsigned.
  localparam logic [9:0] WIN_X_LIMIT = 10'(SCREEN_WIDTH + 7);
  localparam logic [9:0] WIN_Y_LIMIT = 10'(SCREEN_HEIGHT);

  logic       win_hit;
  logic       map_sel;
  logic [7:0] mx;
  logic [7:0] my;
  logic       keep;

  always_comb begin
    win_hit = cfg.lcd_control[LCDC_WIN_EN]
            && (({2'b00, in_pixel_x} + 10'd7) >= {2'b00, cfg.window_x})
            && (in_pixel_y >= cfg.window_y)
            && ({2'b00, cfg.window_x} < WIN_X_LIMIT)
            && ({2'b00, cfg.window_y} < WIN_Y_LIMIT);

    if (win_hit) begin
      mx      = in_pixel_x + 8'd7 - cfg.window_x;
      my      = in_pixel_y - cfg.window_y;
      map_sel = cfg.lcd_control[LCDC_WIN_MAP];
    end else begin
      mx      = in_pixel_x + cfg.scroll_x;
      my      = in_pixel_y + cfg.scroll_y;
      map_sel = cfg.lcd_control[LCDC_BG_MAP];
    end

    push_entry.bank   = in_bank;
    push_entry.data   = in_write_data;
    push_entry.fine_x = mx[2:0];
    push_entry.fine_y = my[2:0];
    push_entry.addr   = in_address;
    push_entry.op     = OP_VRAM_WR;
    keep              = 1'b1;

    case (in_func)
      FUNC_VRAM_WR: push_entry.op = OP_VRAM_WR;
      FUNC_PAL_WR:  push_entry.op = OP_PAL_WR;
      FUNC_PIXEL: begin
        push_entry.addr = (map_sel ? MAP_BASE_HI : MAP_BASE_LO) | {3'b000, my[7:3], mx[7:3]};
        push_entry.op   = cfg.lcd_control[LCDC_ENABLE] ? OP_PIXEL : OP_BLANK;
      end
      default: keep = 1'b0;  // unused code: the beat is taken and dropped
    endcase
  end

  assign push = in_valid && !q_full && keep;

endmodule

// ===== rtl/tbw_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_queue
// Short FIFO of classified jobs between the front and the back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbw_queue import tbw_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  entry_t           slot_r [DEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_comb begin
    wptr_nxt  = wptr_r;
    rptr_nxt  = rptr_r;
    count_nxt = count_r;
    if (push) begin
      wptr_nxt = (wptr_r == PTR_LAST) ? '0 : wptr_r + 1'b1;
    end
    if (pop) begin
      rptr_nxt = (rptr_r == PTR_LAST) ? '0 : rptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      slot_r[wptr_r] <= push_entry;
    end
  end

  assign full       = (count_r == CNT_FULL);
  assign head_valid = (count_r != '0);
  assign head       = slot_r[rptr_r];

  `ASSERT_IMPLIES(a_no_overflow, push, !full, "job pushed into a full queue")
  `ASSERT_IMPLIES(a_no_underflow, pop, head_valid, "job popped from an empty queue")
  `ASSERT_NEXT(a_count_up, push && !pop, count_r == $past(count_r) + 1'b1,
    "queue fill count did not follow a push")

endmodule

// ===== rtl/tbw_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tbw_back
// Execution side: performs memory writes and walks a pixel through the
// tile map read, the tile row read and the palette read, then holds the
// result in the output register. A display-off pixel goes to the palette read only.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tbw_back import tbw_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        head_valid,
  input  entry_t      head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_color_index,
  output logic [7:0]  out_tile_attributes,
  output logic [15:0] out_rgb565
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MAP,
    ST_TILE,
    ST_FETCH,
    ST_IDX,
    ST_PAL,
    ST_COLOR
  } state_t;

  state_t state_r, state_nxt;

  logic [12:0]        map_at_r, map_at_nxt;
  logic [2:0]         fx_r, fx_nxt;
  logic [2:0]         fy_r, fy_nxt;
  logic               blank_r, blank_nxt;
  logic [7:0]         attr_r, attr_nxt;
  logic               tbank_r, tbank_nxt;
  logic [VRAM_AW-1:0] taddr_r, taddr_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic [1:0]         idx_r, idx_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_idx_r, out_idx_nxt;
  logic [7:0]         out_attr_r, out_attr_nxt;
  logic [15:0]        out_rgb_r, out_rgb_nxt;

  // RAM halves: index {bank, odd}.
  logic [3:0]         vram_we;
  logic [VRAM_AW-1:0] vram_raddr;
  logic [7:0]         vram_q [4];
  logic [1:0]         pal_we;
  logic [PAL_AW-1:0]  pal_raddr;
  logic [7:0]         pal_q [2];

  logic        wr_vram, wr_pal;
  logic [7:0]  tile_byte, attr_byte, lo_byte, hi_byte;
  logic [2:0]  row, col;
  logic [1:0]  idx;
  logic [1:0]  shade;
  logic [15:0] rgb;
  logic        out_free;

  assign pop     = (state_r == ST_IDLE) && head_valid;
  assign wr_vram = pop && (head.op == OP_VRAM_WR);
  assign wr_pal  = pop && (head.op == OP_PAL_WR);

  for (genvar i = 0; i < 4; i++) begin : g_vram
    assign vram_we[i] = wr_vram && ({head.bank, head.addr[0]} == 2'(i));
    tbw_ram #(.WIDTH(8), .DEPTH(VRAM_HALF_DEPTH)) u_vram (
      .clk     (clk),
      .wr_en   (vram_we[i]),
      .wr_addr (head.addr[VRAM_AW:1]),
      .wr_data (head.data),
      .rd_addr (vram_raddr),
      .rd_data (vram_q[i])
    );
  end

  for (genvar j = 0; j < 2; j++) begin : g_pal
    assign pal_we[j] = wr_pal && (head.addr[0] == 1'(j));
    tbw_ram #(.WIDTH(8), .DEPTH(PAL_HALF_DEPTH)) u_pal (
      .clk     (clk),
      .wr_en   (pal_we[j]),
      .wr_addr (head.addr[PAL_AW:1]),
      .wr_data (head.data),
      .rd_addr (pal_raddr),
      .rd_data (pal_q[j])
    );
  end

  // Read addresses come from registers so that read data holds while the
  // output register is stalled.
  assign vram_raddr = (state_r == ST_FETCH) ? taddr_r : map_at_r[VRAM_AW:1];
  assign pal_raddr  = {attr_r[2:0], idx_r};

  always_comb begin
    tile_byte = map_at_r[0] ? vram_q[1] : vram_q[0];
    attr_byte = cfg.color_mode ? (map_at_r[0] ? vram_q[3] : vram_q[2]) : 8'h00;
    col       = attr_byte[5] ? ~fx_r : fx_r;
    row       = attr_byte[6] ? ~fy_r : fy_r;
    lo_byte   = tbank_r ? vram_q[2] : vram_q[0];
    hi_byte   = tbank_r ? vram_q[3] : vram_q[1];
    idx       = {hi_byte[bit_r], lo_byte[bit_r]};
    shade     = blank_r ? 2'd0 : cfg.bg_palette_map[{idx_r, 1'b0} +: 2];
    rgb       = cfg.color_mode ? palette565({pal_q[1][6:0], pal_q[0]}) : shade565(shade);
    out_free  = !out_valid_r || !out_stall;
  end

  always_comb begin
    state_nxt     = state_r;
    map_at_nxt    = map_at_r;
    fx_nxt        = fx_r;
    fy_nxt        = fy_r;
    blank_nxt     = blank_r;
    attr_nxt      = attr_r;
    tbank_nxt     = tbank_r;
    taddr_nxt     = taddr_r;
    bit_nxt       = bit_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_idx_nxt   = out_idx_r;
    out_attr_nxt  = out_attr_r;
    out_rgb_nxt   = out_rgb_r;

    case (state_r)
      ST_IDLE: begin
        if (head_valid) begin
          case (head.op)
            OP_PIXEL: begin
              map_at_nxt = head.addr;
              fx_nxt     = head.fine_x;
              fy_nxt     = head.fine_y;
              blank_nxt  = 1'b0;
              state_nxt  = ST_MAP;
            end
            OP_BLANK: begin
              // Display off: palette 0 color 0, or the first fixed shade.
              blank_nxt = 1'b1;
              attr_nxt  = 8'h00;
              idx_nxt   = 2'd0;
              state_nxt = ST_PAL;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MAP: state_nxt = ST_TILE;
      ST_TILE: begin
        // Signed addressing folds to the top bit being the inverted tile
        // sign; the 13-bit wrap falls out of the width.
        attr_nxt  = attr_byte;
        tbank_nxt = attr_byte[3];
        taddr_nxt = {~cfg.lcd_control[LCDC_UNSIGNED] & ~tile_byte[7], tile_byte, row};
        bit_nxt   = ~col;
        state_nxt = ST_FETCH;
      end
      ST_FETCH: state_nxt = ST_IDX;
      ST_IDX: begin
        idx_nxt   = idx;
        state_nxt = ST_PAL;
      end
      ST_PAL: state_nxt = ST_COLOR;
      ST_COLOR: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_attr_nxt  = attr_r;
          out_rgb_nxt   = rgb;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    map_at_r   <= map_at_nxt;
    fx_r       <= fx_nxt;
    fy_r       <= fy_nxt;
    blank_r    <= blank_nxt;
    attr_r     <= attr_nxt;
    tbank_r    <= tbank_nxt;
    taddr_r    <= taddr_nxt;
    bit_r      <= bit_nxt;
    idx_r      <= idx_nxt;
    out_idx_r  <= out_idx_nxt;
    out_attr_r <= out_attr_nxt;
    out_rgb_r  <= out_rgb_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_color_index     = out_idx_r;
  assign out_tile_attributes = out_attr_r;
  assign out_rgb565          = out_rgb_r;

  `ASSERT_IMPLIES(a_write_when_idle, (|vram_we) || (|pal_we), state_r == ST_IDLE,
    "memory written while a pixel is in flight")
  `ASSERT_IMPLIES(a_result_from_color, $rose(out_valid_r), $past(state_r) == ST_COLOR,
    "result beat raised outside the color step")
  `ASSERT_NEXT(a_wait_on_stall, (state_r == ST_COLOR) && out_valid_r && out_stall,
    state_r == ST_COLOR, "finished pixel left the color step while output stalled")

endmodule

// ===== rtl/tile_background_window_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_background_window_pixel
// Tile based background and window pixel generator with its video and
// palette memories.
// ----------------------------------------------------------------------------
// A video memory or palette write beat is written into its memory at the
// clock edge at which it leaves the two-entry job queue, so writes stream at
// one per cycle while no pixel is in flight. A pixel request holds the back
// end from the cycle in which it leaves the queue through three dependent
// registered memory reads (tile map and attribute byte, the tile row byte
// pair, the palette byte pair), each with an address step and a data step.
// The output register loads at the end of the last data step, so the result
// beat shows in the same cycle as the next job can leave the queue. A pixel
// with the display off skips the first two reads. A finished pixel waits in
// its last step while the previous result beat is still stalled. Pixels are
// worked one at a time; the queue keeps taking beats meanwhile until it is
// full. The memories have no reset or clearing pass: a byte read before it
// was ever written returns an unspecified value. The user must write
// configuration only while no beat is in flight; the block itself does
// not enforce this.
// ----------------------------------------------------------------------------
module tile_background_window_pixel import tbw_pkg::*; #(
  parameter int SCREEN_WIDTH  = 160,
  parameter int SCREEN_HEIGHT = 144
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,

  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_func,
  input  logic        in_bank,
  input  logic [12:0] in_address,
  input  logic [7:0]  in_write_data,
  input  logic [7:0]  in_pixel_x,
  input  logic [7:0]  in_pixel_y,

  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_color_index,
  output logic [7:0]  out_tile_attributes,
  output logic [15:0] out_rgb565
);

  cfg_t   cfg_r;
  logic   q_full;
  logic   push;
  entry_t push_entry;
  logic   pop;
  logic   head_valid;
  entry_t head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.lcd_control    <= LCDC_RESET;
      cfg_r.scroll_x       <= 8'h00;
      cfg_r.scroll_y       <= 8'h00;
      cfg_r.window_x       <= 8'h00;
      cfg_r.window_y       <= 8'h00;
      cfg_r.bg_palette_map <= BG_PALETTE_RESET;
      cfg_r.color_mode     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LCDC:       cfg_r.lcd_control    <= cfg_wdata;
        CFG_SCROLL_X:   cfg_r.scroll_x       <= cfg_wdata;
        CFG_SCROLL_Y:   cfg_r.scroll_y       <= cfg_wdata;
        CFG_WINDOW_X:   cfg_r.window_x       <= cfg_wdata;
        CFG_WINDOW_Y:   cfg_r.window_y       <= cfg_wdata;
        CFG_BG_PALETTE: cfg_r.bg_palette_map <= cfg_wdata;
        CFG_COLOR_MODE: cfg_r.color_mode     <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign in_stall = q_full;

  tbw_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .in_valid      (in_valid),
    .in_func       (in_func),
    .in_bank       (in_bank),
    .in_address    (in_address),
    .in_write_data (in_write_data),
    .in_pixel_x    (in_pixel_x),
    .in_pixel_y    (in_pixel_y),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .push          (push),
    .push_entry    (push_entry)
  );

  tbw_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  tbw_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg                 (cfg_r),
    .head_valid          (head_valid),
    .head                (head),
    .pop                 (pop),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_color_index     (out_color_index),
    .out_tile_attributes (out_tile_attributes),
    .out_rgb565          (out_rgb565)
  );

endmodule

// ===== test/tb_tile_background_window_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_tile_background_window_pixel
// Self-checking bench for the background and window pixel generator. A
// queue of input beats feeds a clocked driver, and a clocked monitor checks
// every pixel result against a shadow of the block's memories and
// registers. A pixel never reads a byte that was not written: when the
// shadow finds one missing, it queues a write with random data first.
// The run steps through register settings that include display off, the
// window at and just past the screen edges, both tile addressing modes
// and both color modes.
// ----------------------------------------------------------------------------
module tb_tile_background_window_pixel import tbw_pkg::*; ();

  localparam int SCREEN_W      = 160;
  localparam int SCREEN_H      = 144;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES   = 400;
  localparam int QUIET_LIMIT   = 3000;

  localparam logic [1:0]  FUNC_UNUSED      = 2'd3;
  localparam logic [12:0] TILE_BASE_SIGNED = 13'h1000;

  typedef struct packed {
    logic [1:0]  func;
    logic        bank;
    logic [12:0] address;
    logic [7:0]  write_data;
    logic [7:0]  pixel_x;
    logic [7:0]  pixel_y;
  } beat_t;

  typedef struct packed {
    logic [1:0]  color_index;
    logic [7:0]  tile_attributes;
    logic [15:0] rgb565;
  } pixel_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [7:0]  cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_func = '0;
  logic        in_bank = 1'b0;
  logic [12:0] in_address = '0;
  logic [7:0]  in_write_data = '0;
  logic [7:0]  in_pixel_x = '0;
  logic [7:0]  in_pixel_y = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_color_index;
  logic [7:0]  out_tile_attributes;
  logic [15:0] out_rgb565;

  tile_background_window_pixel #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_func            (in_func),
    .in_bank            (in_bank),
    .in_address         (in_address),
    .in_write_data      (in_write_data),
    .in_pixel_x         (in_pixel_x),
    .in_pixel_y         (in_pixel_y),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_color_index    (out_color_index),
    .out_tile_attributes(out_tile_attributes),
    .out_rgb565         (out_rgb565)
  );

  // Shadow of the block: registers, memories and which bytes hold data.
  logic [7:0] lcdc_r = LCDC_RESET;
  logic [7:0] scx_r = '0;
  logic [7:0] scy_r = '0;
  logic [7:0] wx_r = '0;
  logic [7:0] wy_r = '0;
  logic [7:0] bgp_r = BG_PALETTE_RESET;
  logic       cm_r = 1'b0;
  logic [7:0] vram_img [2*8192];
  bit         vram_known [2*8192];
  logic [7:0] pal_img [64];
  bit         pal_known [64];

  beat_t  beat_q [$];
  pixel_t pixel_q [$];

  int unsigned send_max = 18;
  int unsigned recv_max = 18;
  int unsigned hold_requests = 0;
  int unsigned beats_sent = 0;
  int unsigned pixels_checked = 0;
  int unsigned settings_run = 0;
  int unsigned errors = 0;
  int unsigned longest_in_stall = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] pack_rgb(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  function automatic logic [15:0] shade_rgb(logic [1:0] s);
    case (s)
      2'd0:    return pack_rgb(8'd224, 8'd232, 8'd184);
      2'd1:    return pack_rgb(8'd140, 8'd160, 8'd112);
      2'd2:    return pack_rgb(8'd72, 8'd88, 8'd72);
      default: return pack_rgb(8'd24, 8'd32, 8'd28);
    endcase
  endfunction

  task automatic post_vram_write(input logic bnk, input logic [12:0] addr,
                                 input logic [7:0] data);
    beat_t b;
    b.func       = FUNC_VRAM_WR;
    b.bank       = bnk;
    b.address    = addr;
    b.write_data = data;
    b.pixel_x    = 8'($urandom);
    b.pixel_y    = 8'($urandom);
    vram_img[{bnk, addr}]   = data;
    vram_known[{bnk, addr}] = 1'b1;
    beat_q.push_back(b);
  endtask

  task automatic post_palette_write(input logic [12:0] addr, input logic [7:0] data);
    beat_t b;
    b.func       = FUNC_PAL_WR;
    b.bank       = 1'($urandom);
    b.address    = addr;
    b.write_data = data;
    b.pixel_x    = 8'($urandom);
    b.pixel_y    = 8'($urandom);
    pal_img[addr[5:0]]   = data;
    pal_known[addr[5:0]] = 1'b1;
    beat_q.push_back(b);
  endtask

  task automatic post_ignored(input logic bnk, input logic [12:0] addr, input logic [7:0] data,
                              input logic [7:0] x, input logic [7:0] y);
    beat_t b;
    b.func       = FUNC_UNUSED;
    b.bank       = bnk;
    b.address    = addr;
    b.write_data = data;
    b.pixel_x    = x;
    b.pixel_y    = y;
    beat_q.push_back(b);
  endtask

  // Reads of the shadow fill in any byte that was never written.
  task automatic fetch_vram(input logic bnk, input logic [12:0] addr, output logic [7:0] val);
    if (!vram_known[{bnk, addr}]) post_vram_write(bnk, addr, 8'($urandom));
    val = vram_img[{bnk, addr}];
  endtask

  task automatic fetch_pal(input logic [5:0] at, output logic [7:0] val);
    if (!pal_known[at]) post_palette_write({7'($urandom), at}, 8'($urandom));
    val = pal_img[at];
  endtask

  task automatic palette_rgb(input logic [2:0] pal, input logic [1:0] idx,
                             output logic [15:0] rgb);
    logic [5:0]  at;
    logic [7:0]  lo, hi;
    logic [14:0] v;
    logic [7:0]  red, grn, blu;
    at = {pal, idx, 1'b0};
    fetch_pal(at, lo);
    fetch_pal(at + 6'd1, hi);
    v   = {hi[6:0], lo};
    red = 8'(int'(v[4:0]) * 255 / 31);
    grn = 8'(int'(v[9:5]) * 255 / 31);
    blu = 8'(int'(v[14:10]) * 255 / 31);
    rgb = pack_rgb(red, grn, blu);
  endtask

  task automatic render_pixel(input logic [7:0] x, input logic [7:0] y, output pixel_t res);
    int          wx_left;
    bit          in_window;
    logic [7:0]  mx, my, tile, attr, lo, hi;
    logic [12:0] base, map_at, taddr;
    logic [2:0]  col, row, bit_pos;
    logic        tbank;
    logic [1:0]  idx;
    logic [15:0] rgb;
    if (!lcdc_r[LCDC_ENABLE]) begin
      // Display off bypasses the mono shade register.
      if (cm_r) palette_rgb(3'd0, 2'd0, rgb);
      else rgb = shade_rgb(2'd0);
      res.color_index     = 2'd0;
      res.tile_attributes = 8'd0;
      res.rgb565          = rgb;
      return;
    end
    wx_left   = int'(wx_r) - 7;
    in_window = lcdc_r[LCDC_WIN_EN] && int'(x) >= wx_left && y >= wy_r &&
                wx_left < SCREEN_W && int'(wy_r) < SCREEN_H;
    if (in_window) begin
      mx   = x - 8'(wx_left);
      my   = y - wy_r;
      base = lcdc_r[LCDC_WIN_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
    end else begin
      mx   = x + scx_r;
      my   = y + scy_r;
      base = lcdc_r[LCDC_BG_MAP] ? MAP_BASE_HI : MAP_BASE_LO;
    end
    map_at = base + {my[7:3], 5'd0} + {8'd0, mx[7:3]};
    fetch_vram(1'b0, map_at, tile);
    attr = 8'd0;
    if (cm_r) fetch_vram(1'b1, map_at, attr);
    col   = attr[5] ? 3'd7 - mx[2:0] : mx[2:0];
    row   = attr[6] ? 3'd7 - my[2:0] : my[2:0];
    tbank = cm_r & attr[3];
    if (lcdc_r[LCDC_UNSIGNED]) taddr = {1'b0, tile, 4'd0} + {9'd0, row, 1'b0};
    else taddr = TILE_BASE_SIGNED + {tile[7], tile, 4'd0} + {9'd0, row, 1'b0};
    fetch_vram(tbank, taddr, lo);
    fetch_vram(tbank, taddr + 13'd1, hi);
    bit_pos = 3'd7 - col;
    idx     = {hi[bit_pos], lo[bit_pos]};
    if (cm_r) palette_rgb(attr[2:0], idx, rgb);
    else rgb = shade_rgb(bgp_r[{idx, 1'b0} +: 2]);
    res.color_index     = idx;
    res.tile_attributes = attr;
    res.rgb565          = rgb;
  endtask

  task automatic post_pixel(input logic [7:0] x, input logic [7:0] y);
    pixel_t res;
    beat_t  b;
    render_pixel(x, y, res);
    b.func       = FUNC_PIXEL;
    b.bank       = 1'($urandom);
    b.address    = 13'($urandom);
    b.write_data = 8'($urandom);
    b.pixel_x    = x;
    b.pixel_y    = y;
    beat_q.push_back(b);
    pixel_q.push_back(res);
  endtask

  task automatic post_random_item();
    int pick;
    pick = $urandom_range(99, 0);
    if (pick < 62) begin
      // Mostly on screen, sometimes anywhere in the 8-bit range.
      if ($urandom_range(6, 0) == 0) post_pixel(8'($urandom), 8'($urandom));
      else post_pixel(8'($urandom_range(SCREEN_W - 1, 0)), 8'($urandom_range(SCREEN_H - 1, 0)));
    end else if (pick < 82) begin
      post_vram_write(1'($urandom), 13'($urandom), 8'($urandom));
    end else if (pick < 94) begin
      post_palette_write(13'($urandom), 8'($urandom));
    end else begin
      post_ignored(1'($urandom), 13'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  task automatic set_reg(input logic [2:0] idx, input logic [7:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_LCDC:       lcdc_r = val;
      CFG_SCROLL_X:   scx_r = val;
      CFG_SCROLL_Y:   scy_r = val;
      CFG_WINDOW_X:   wx_r = val;
      CFG_WINDOW_Y:   wy_r = val;
      CFG_BG_PALETTE: bgp_r = val;
      CFG_COLOR_MODE: cm_r = val[0];
      default: ;
    endcase
  endtask

  // Polled on the falling edge so that the driver's updates have settled.
  task automatic drain();
    @(negedge clk);
    while (beat_q.size() != 0 || in_valid || pixel_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(input bit do_cfg, input logic [7:0] lcdc_v, input logic [7:0] scx_v,
                           input logic [7:0] scy_v, input logic [7:0] wx_v,
                           input logic [7:0] wy_v, input logic [7:0] bgp_v, input bit cm_v,
                           input int n_items, input int smax, input int rmax,
                           input bit squeeze);
    if (do_cfg) begin
      set_reg(CFG_LCDC, lcdc_v);
      set_reg(CFG_SCROLL_X, scx_v);
      set_reg(CFG_SCROLL_Y, scy_v);
      set_reg(CFG_WINDOW_X, wx_v);
      set_reg(CFG_WINDOW_Y, wy_v);
      set_reg(CFG_BG_PALETTE, bgp_v);
      set_reg(CFG_COLOR_MODE, {7'($urandom), cm_v});
      @(posedge clk);
      cfg_we <= 1'b0;
    end
    @(negedge clk);
    send_max = smax;
    recv_max = rmax;
    if (squeeze) hold_requests++;
    settings_run++;
    post_pixel(8'd0, 8'd0);
    post_pixel(8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
    post_pixel(8'hFF, 8'hFF);
    repeat (n_items) post_random_item();
    drain();
  endtask

  // Driver: offers queued beats, idling a drawn number of cycles after each.
  int unsigned send_wait = 0;
  int unsigned stall_run = 0;
  beat_t       next_beat;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid  <= 1'b0;
      send_wait = 0;
    end else begin
      if (in_valid && in_stall) begin
        stall_run++;
        if (stall_run > longest_in_stall) longest_in_stall = stall_run;
      end else begin
        stall_run = 0;
      end
      if (in_valid && !in_stall) beats_sent++;
      if (!in_valid || !in_stall) begin
        if (send_wait != 0) begin
          send_wait--;
          in_valid <= 1'b0;
        end else if (beat_q.size() != 0) begin
          next_beat = beat_q.pop_front();
          in_func       <= next_beat.func;
          in_bank       <= next_beat.bank;
          in_address    <= next_beat.address;
          in_write_data <= next_beat.write_data;
          in_pixel_x    <= next_beat.pixel_x;
          in_pixel_y    <= next_beat.pixel_y;
          in_valid      <= 1'b1;
          send_wait = $urandom_range(send_max, 0);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each result beat and stalls a drawn number of cycles
  // after it, or for a long stretch when a hold-off is requested.
  int unsigned recv_wait = 0;
  int unsigned hold_left = 0;
  int unsigned hold_seen = 0;
  pixel_t      got, want;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_wait = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        got.color_index     = out_color_index;
        got.tile_attributes = out_tile_attributes;
        got.rgb565          = out_rgb565;
        if (pixel_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat: idx %0d attr 0x%02h rgb 0x%04h",
                   $time, got.color_index, got.tile_attributes, got.rgb565);
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch: exp idx %0d attr %02h rgb %04h, got idx %0d attr %02h rgb %04h",
                     $time, want.color_index, want.tile_attributes, want.rgb565,
                     got.color_index, got.tile_attributes, got.rgb565);
          end
        end
        pixels_checked++;
        recv_wait = $urandom_range(recv_max, 0);
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (recv_wait != 0) begin
        recv_wait--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("%0t: no beat moved for %0d cycles", $time, quiet_cycles);
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  initial begin
    logic [7:0] lcdc_v;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Field extremes and the unused function code, at reset settings.
    post_vram_write(1'b1, 13'h1FFF, 8'hFF);
    post_vram_write(1'b0, 13'h0000, 8'h00);
    post_palette_write(13'h1FFF, 8'hFF);
    post_palette_write(13'h0000, 8'h00);
    post_ignored(1'b1, 13'h1FFF, 8'hFF, 8'hFF, 8'hFF);
    post_ignored(1'b0, 13'h0000, 8'h00, 8'h00, 8'h00);
    run_phase(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 20, 18, 18, 1'b0);

    // Display off, mono and then color.
    run_phase(1'b1, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0, 10, 18, 18, 1'b0);
    run_phase(1'b1, 8'hFE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h1B, 1'b1, 10, 5, 18, 1'b0);
    // Window enabled but placed off screen, full scroll.
    run_phase(1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b1, 35, 18, 3, 1'b0);
    // Window covers the screen, signed addressing, no idling at all.
    run_phase(1'b1, 8'h69, 8'h00, 8'h00, 8'd7, 8'd0, 8'hE4, 1'b0, 35, 0, 0, 1'b0);
    // Window at its last on-screen position; the receiver holds off.
    run_phase(1'b1, 8'h29, 8'd3, 8'd250, 8'd166, 8'd143, 8'h9C, 1'b1, 35, 0, 18, 1'b1);
    // Window one past the screen edge in both directions.
    run_phase(1'b1, 8'h39, 8'd17, 8'd200, 8'd167, 8'd144, 8'($urandom), 1'b1, 20, 18, 18,
              1'b0);

    for (int p = 0; p < 5; p++) begin
      lcdc_v = 8'($urandom);
      if ($urandom_range(5, 0) != 0) lcdc_v[LCDC_ENABLE] = 1'b1;
      run_phase(1'b1, lcdc_v, 8'($urandom), 8'($urandom), 8'($urandom_range(170, 0)),
                8'($urandom_range(150, 0)), 8'($urandom), 1'($urandom),
                35, (p == 1) ? 0 : 18, (p == 3) ? 0 : 18, p == 2);
    end

    $display("Run moved %0d input beats over %0d register settings and checked %0d pixels.",
             beats_sent, settings_run, pixels_checked);
    $display("Longest input stall was %0d cycles; %0d mismatches.", longest_in_stall, errors);
    if (errors == 0 && pixel_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
